[rtl/pmst_pkg.sv]
package pmst_pkg;

  // Fixed field widths of the edge and result words.
  localparam int unsigned VertexW = 5;
  localparam int unsigned WeightW = 16;
  localparam int unsigned CountW  = 6;
  localparam int unsigned CostW   = 21;

  // Widest vertex index and weight any configuration of the block may use.
  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 32;

  // Compare width wide enough for a vertex field and any vertex count.
  localparam int unsigned CmpW = 7;

  localparam logic [CountW-1:0] VcountReset = 6'd32;

  // Commands broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic             init;
    logic             rd;
    logic             upd;
    logic             wr;
    logic             clr;
    logic [AddrW-1:0] a;
    logic [AddrW-1:0] b;
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] clr_addr;
    logic [DataW-1:0] w;
  } cell_ctl_t;

endpackage

[rtl/pmst_ifs.sv]
// Edge channel: one undirected weighted edge per word.
interface pmst_edge_if;
  logic                          valid;
  logic                          ready;
  logic [pmst_pkg::VertexW-1:0]  from_vertex;
  logic [pmst_pkg::VertexW-1:0]  to_vertex;
  logic [pmst_pkg::WeightW-1:0]  weight;
  logic                          last_edge;

  modport source (output valid, from_vertex, to_vertex, weight, last_edge, input ready);
  modport sink   (input valid, from_vertex, to_vertex, weight, last_edge, output ready);
endinterface

// Result channel: one tree edge per word.
interface pmst_res_if;
  logic                          valid;
  logic                          ready;
  logic [pmst_pkg::VertexW-1:0]  parent_vertex;
  logic [pmst_pkg::VertexW-1:0]  child_vertex;
  logic [pmst_pkg::WeightW-1:0]  tree_weight;
  logic                          reached;
  logic [pmst_pkg::CostW-1:0]    cost_sum;
  logic                          last_result;

  modport source (output valid, parent_vertex, child_vertex, tree_weight, reached,
                  cost_sum, last_result, input ready);
  modport sink   (input valid, parent_vertex, child_vertex, tree_weight, reached,
                  cost_sum, last_result, output ready);
endinterface

[rtl/pmst_cell.sv]
module pmst_cell #(
  parameter int unsigned MaxV       = 32,
  parameter int unsigned WeightBits = 16,
  parameter int unsigned Index      = 0
) (
  input  logic                              clk_i,
  input  pmst_pkg::cell_ctl_t               ctl_i,
  input  logic [$clog2(MaxV+1)-1:0]         n_i,
  input  logic [WeightBits:0]               ch_key_i,
  input  logic [$clog2(MaxV)-1:0]           ch_idx_i,
  output logic [WeightBits:0]               ch_key_o,
  output logic [$clog2(MaxV)-1:0]           ch_idx_o,
  output logic [WeightBits:0]               key_o,
  output logic [$clog2(MaxV)-1:0]           parent_o
);

  localparam int unsigned IW = $clog2(MaxV);
  localparam int unsigned NW = $clog2(MaxV + 1);
  localparam int unsigned KW = WeightBits + 1;
  localparam logic [IW-1:0] MyIdx  = IW'(Index);
  localparam logic [KW-1:0] KeyInf = {1'b1, {WeightBits{1'b0}}};

  // Column of the adjacency matrix that belongs to this vertex.
  logic [WeightBits-1:0] mem [MaxV];
  logic [WeightBits-1:0] rd_q;
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [WeightBits-1:0] wdata;

  logic [KW-1:0] key_q;
  logic [IW-1:0] par_q;
  logic          it_q;
  logic [KW-1:0] ch_key_q;
  logic [IW-1:0] ch_idx_q;
  logic          cand;
  logic          take;
  logic [IW-1:0] src;

  assign src = ctl_i.src[IW-1:0];

  // An edge lands in the column of each endpoint, at the other endpoint's row.
  always_comb begin
    we    = 1'b0;
    waddr = ctl_i.a[IW-1:0];
    wdata = ctl_i.w[WeightBits-1:0];
    if (ctl_i.clr) begin
      we    = 1'b1;
      waddr = ctl_i.clr_addr[IW-1:0];
      wdata = '0;
    end else if (ctl_i.wr) begin
      if (ctl_i.a[IW-1:0] == MyIdx) begin
        we    = 1'b1;
        waddr = ctl_i.b[IW-1:0];
      end else if (ctl_i.b[IW-1:0] == MyIdx) begin
        we    = 1'b1;
        waddr = ctl_i.a[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl_i.rd) begin
      rd_q <= mem[src];
    end
  end

  // Prim work state of this vertex.
  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      key_q <= (Index == 0) ? '0 : KeyInf;
      par_q <= '0;
      it_q  <= 1'b0;
    end else begin
      if (ctl_i.rd && src == MyIdx) begin
        it_q <= 1'b1;
      end
      if (ctl_i.upd && !it_q && rd_q != '0 && {1'b0, rd_q} < key_q) begin
        key_q <= {1'b0, rd_q};
        par_q <= src;
      end
    end
  end

  // Running minimum passed down the row; a strict compare keeps the lower index.
  assign cand = !it_q && (NW'(Index) < n_i);
  assign take = cand && (key_q < ch_key_i);

  always_ff @(posedge clk_i) begin
    ch_key_q <= take ? key_q : ch_key_i;
    ch_idx_q <= take ? MyIdx : ch_idx_i;
  end

  assign ch_key_o = ch_key_q;
  assign ch_idx_o = ch_idx_q;
  assign key_o    = key_q;
  assign parent_o = par_q;

endmodule

[rtl/prim_mst_dense_top.sv]
// Minimum spanning tree engine for a dense graph. Edges arrive one word per cycle while
// the block is loading and are written symmetrically into a cleared adjacency matrix; a
// word with last_edge set starts Prim's search from vertex 0 over vertex_count vertices.
// The matrix is held as one column memory in each cell of a row of MAX_VERTICES cells, and
// every search round passes a running minimum down that row. A run takes at most n - 1
// rounds, then gives one result word per cycle, unless the result channel stalls, for
// vertices 1 to n - 1 in ascending order. After the last result is produced, and after
// reset, the matrix is swept clear while no edge is accepted.
module prim_mst_dense_top #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pmst_pkg::CountW-1:0]   cfg_wdata_i,
  pmst_edge_if.sink                     edge_i,
  pmst_res_if.source                    res_o
);

  localparam int unsigned IW   = $clog2(MAX_VERTICES);
  localparam int unsigned NW   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned KW   = WEIGHT_BITS + 1;
  localparam int unsigned CmpW = pmst_pkg::CmpW;
  localparam logic [KW-1:0] KeyInf = {1'b1, {WEIGHT_BITS{1'b0}}};
  localparam logic [NW-1:0] NMax   = NW'(MAX_VERTICES);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StLoad  = 3'd1;
  localparam logic [2:0] StInit  = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StUpd   = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  logic [2:0]                   st_q, st_d;
  logic [NW-1:0]                cnt_q, cnt_d;
  logic [NW-1:0]                rnd_q, rnd_d;
  logic [NW-1:0]                idx_q, idx_d;
  logic [IW-1:0]                src_q, src_d;
  logic [pmst_pkg::CostW-1:0]   total_q, total_d;
  logic [pmst_pkg::CountW-1:0]  vcount_q;
  logic [CmpW-1:0]              vc_ext;
  logic [NW-1:0]                n;

  pmst_pkg::cell_ctl_t          ctl;
  logic [KW-1:0]                ch_key [MAX_VERTICES+1];
  logic [IW-1:0]                ch_idx [MAX_VERTICES+1];
  logic [KW-1:0]                cell_key [MAX_VERTICES];
  logic [IW-1:0]                cell_par [MAX_VERTICES];

  logic                         in_acc;
  logic                         in_range;
  logic                         found;
  logic                         emit_ld;

  // Vertex count register; out-of-range values clamp to the usable span.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= pmst_pkg::VcountReset;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  assign vc_ext = CmpW'(vcount_q);

  always_comb begin
    if (vc_ext < CmpW'(2)) begin
      n = NW'(2);
    end else if (vc_ext > CmpW'(MAX_VERTICES)) begin
      n = NMax;
    end else begin
      n = NW'(vc_ext);
    end
  end

  // Edge intake.
  assign edge_i.ready = (st_q == StLoad);
  assign in_acc       = edge_i.valid && edge_i.ready;
  assign in_range     = (CmpW'(edge_i.from_vertex) < CmpW'(n)) &&
                        (CmpW'(edge_i.to_vertex) < CmpW'(n));

  // Commands to the cell row.
  always_comb begin
    ctl          = '0;
    ctl.init     = (st_q == StInit);
    ctl.rd       = (st_q == StRead);
    ctl.upd      = (st_q == StUpd);
    ctl.wr       = in_acc && in_range;
    ctl.clr      = (st_q == StClear);
    ctl.a        = pmst_pkg::AddrW'(edge_i.from_vertex);
    ctl.b        = pmst_pkg::AddrW'(edge_i.to_vertex);
    ctl.src      = pmst_pkg::AddrW'(src_q);
    ctl.clr_addr = pmst_pkg::AddrW'(cnt_q[IW-1:0]);
    ctl.w        = pmst_pkg::DataW'(edge_i.weight);
  end

  assign ch_key[0] = KeyInf;
  assign ch_idx[0] = '0;

  for (genvar j = 0; j < MAX_VERTICES; j++) begin : g_cell
    pmst_cell #(
      .MaxV       (MAX_VERTICES),
      .WeightBits (WEIGHT_BITS),
      .Index      (j)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .n_i      (n),
      .ch_key_i (ch_key[j]),
      .ch_idx_i (ch_idx[j]),
      .ch_key_o (ch_key[j+1]),
      .ch_idx_o (ch_idx[j+1]),
      .key_o    (cell_key[j]),
      .parent_o (cell_par[j])
    );
  end

  assign found = !ch_key[MAX_VERTICES][WEIGHT_BITS];

  // Selected vertex for the result word.
  logic [KW-1:0]              sel_key;
  logic [IW-1:0]              sel_par;
  logic                       sel_reached;
  logic [pmst_pkg::DataW-1:0] tw_ext;
  logic [CmpW-1:0]            par_ext;
  logic [CmpW-1:0]            idx_ext;

  assign sel_key     = cell_key[idx_q[IW-1:0]];
  assign sel_par     = cell_par[idx_q[IW-1:0]];
  assign sel_reached = !sel_key[WEIGHT_BITS];
  assign tw_ext      = sel_reached ? pmst_pkg::DataW'(sel_key[WEIGHT_BITS-1:0]) : '0;
  assign par_ext     = sel_reached ? CmpW'(sel_par) : '0;
  assign idx_ext     = CmpW'(idx_q);
  assign emit_ld     = (st_q == StEmit) && (!res_o.valid || res_o.ready);

  // Sequencer: load, initialize, scan and update rounds, emit, clear.
  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    src_d   = src_q;
    total_d = total_q;
    case (st_q)
      StClear: begin
        cnt_d = cnt_q + NW'(1);
        if (cnt_q == NMax - NW'(1)) begin
          st_d = StLoad;
        end
      end
      StLoad: begin
        if (in_acc && edge_i.last_edge) begin
          st_d = StInit;
        end
      end
      StInit: begin
        st_d  = StScan;
        cnt_d = '0;
        rnd_d = '0;
      end
      StScan: begin
        cnt_d = cnt_q + NW'(1);
        if (cnt_q == NMax) begin
          if (found) begin
            src_d = ch_idx[MAX_VERTICES];
            st_d  = StRead;
          end else begin
            st_d    = StEmit;
            idx_d   = NW'(1);
            total_d = '0;
          end
        end
      end
      StRead: begin
        st_d = StUpd;
      end
      StUpd: begin
        rnd_d = rnd_q + NW'(1);
        cnt_d = '0;
        if (rnd_q + NW'(1) == n - NW'(1)) begin
          st_d    = StEmit;
          idx_d   = NW'(1);
          total_d = '0;
        end else begin
          st_d = StScan;
        end
      end
      StEmit: begin
        if (emit_ld) begin
          idx_d   = idx_q + NW'(1);
          total_d = total_q + tw_ext[pmst_pkg::CostW-1:0];
          if (idx_q == n - NW'(1)) begin
            st_d  = StClear;
            cnt_d = '0;
          end
        end
      end
      default: begin
        st_d  = StClear;
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StClear;
      cnt_q <= '0;
      rnd_q <= '0;
      idx_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      rnd_q <= rnd_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q   <= src_d;
    total_q <= total_d;
  end

  // Output register for the result word.
  logic                          ov_q;
  logic [pmst_pkg::VertexW-1:0]  o_par_q;
  logic [pmst_pkg::VertexW-1:0]  o_child_q;
  logic [pmst_pkg::WeightW-1:0]  o_tw_q;
  logic                          o_reached_q;
  logic [pmst_pkg::CostW-1:0]    o_total_q;
  logic                          o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit_ld) begin
      ov_q <= 1'b1;
    end else if (res_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ld) begin
      o_par_q     <= par_ext[pmst_pkg::VertexW-1:0];
      o_child_q   <= idx_ext[pmst_pkg::VertexW-1:0];
      o_tw_q      <= tw_ext[pmst_pkg::WeightW-1:0];
      o_reached_q <= sel_reached;
      o_total_q   <= total_d;
      o_last_q    <= (idx_q == n - NW'(1));
    end
  end

  assign res_o.valid         = ov_q;
  assign res_o.parent_vertex = o_par_q;
  assign res_o.child_vertex  = o_child_q;
  assign res_o.tree_weight   = o_tw_q;
  assign res_o.reached       = o_reached_q;
  assign res_o.cost_sum      = o_total_q;
  assign res_o.last_result   = o_last_q;

endmodule

[rtl/pmst_checker.sv]
module pmst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_last_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [pmst_pkg::VertexW-1:0]  child_i,
  input logic [pmst_pkg::WeightW-1:0]  tree_weight_i,
  input logic                          reached_i,
  input logic                          last_result_i
);

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(child_i))
    else $error("result word changed while stalled");

  // Unreached vertices carry no weight.
  a_unreached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !reached_i |-> tree_weight_i == '0)
    else $error("unreached vertex reported with weight");

  // Vertex 0 is the root and is never reported.
  a_child: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> child_i != '0)
    else $error("root reported as child");

  // The final edge starts a run, so intake closes.
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("edge intake open after final edge");

  // No edges are taken in the middle of emission.
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_result_i |=> !in_ready_i)
    else $error("edge intake open during emission");

endmodule

bind prim_mst_dense_top pmst_checker u_pmst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (edge_i.valid),
  .in_ready_i    (edge_i.ready),
  .in_last_i     (edge_i.last_edge),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .child_i       (res_o.child_vertex),
  .tree_weight_i (res_o.tree_weight),
  .reached_i     (res_o.reached),
  .last_result_i (res_o.last_result)
);

[sim/tb_prim_mst_dense_ifs.sv]
`timescale 1ns / 100ps

// Testbench-side handles are plain instances of the RTL interfaces; this file only
// groups the small types the scoreboard uses.
package tb_pmst_types_pkg;

  typedef struct packed {
    logic [pmst_pkg::VertexW-1:0] parent_vertex;
    logic [pmst_pkg::VertexW-1:0] child_vertex;
    logic [pmst_pkg::WeightW-1:0] tree_weight;
    logic                         reached;
    logic [pmst_pkg::CostW-1:0]   cost_sum;
    logic                         last_result;
  } tree_word_t;
endpackage

[sim/tb_prim_mst_dense_top.sv]
`timescale 1ns / 100ps

module tb_prim_mst_dense_top;

  localparam int unsigned NumV = 32;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned VW = pmst_pkg::VertexW;
  localparam int unsigned WW = pmst_pkg::WeightW;
  localparam int unsigned CW = pmst_pkg::CountW;
  localparam int unsigned SW = pmst_pkg::CostW;

  // Tracks the graph being loaded and the tree words it must produce.
  class mst_scoreboard;
    logic [WW-1:0]                  adj [NumV][NumV];
    logic [CW-1:0]                  vcount;
    tb_pmst_types_pkg::tree_word_t  pending_words[$];
    int                             err_cnt;
    int                             graphs_done;
    int                             words_checked;

    function new();
      foreach (adj[i, j]) adj[i][j] = '0;
      vcount = pmst_pkg::VcountReset;
      err_cnt = 0;
      graphs_done = 0;
      words_checked = 0;
    endfunction

    function void set_count(logic [CW-1:0] c);
      vcount = c;
    endfunction

    // Stores an edge and, on the last one, computes the expected tree.
    function void note_edge(logic [VW-1:0] u, logic [VW-1:0] v,
                            logic [WW-1:0] w, logic last);
      int n;
      int src;
      logic [WW:0] lo;
      logic [WW:0] key [NumV];
      int par [NumV];
      bit done [NumV];
      logic [SW-1:0] total;
      tb_pmst_types_pkg::tree_word_t tw;
      n = (vcount < 2) ? 2 : ((vcount > NumV) ? NumV : int'(vcount));
      if (u < n && v < n) begin
        adj[u][v] = w;
        adj[v][u] = w;
      end
      if (!last) return;
      for (int i = 0; i < NumV; i++) begin
        key[i] = 1 << WW;
        par[i] = 0;
        done[i] = 0;
      end
      key[0] = 0;
      for (int r = 0; r + 1 < n; r++) begin
        src = n;
        lo = 1 << WW;
        for (int j = 0; j < n; j++) begin
          if (!done[j] && key[j] < lo) begin
            lo = key[j];
            src = j;
          end
        end
        if (src >= n) break;
        done[src] = 1;
        for (int j = 0; j < n; j++) begin
          if (!done[j] && adj[src][j] != 0 && adj[src][j] < key[j]) begin
            key[j] = adj[src][j];
            par[j] = src;
          end
        end
      end
      total = '0;
      for (int i = 1; i < n; i++) begin
        tw.reached = key[i][WW] == 1'b0;
        tw.tree_weight = tw.reached ? key[i][WW-1:0] : '0;
        tw.parent_vertex = tw.reached ? par[i][VW-1:0] : '0;
        tw.child_vertex = i[VW-1:0];
        total += tw.tree_weight;
        tw.cost_sum = total;
        tw.last_result = (i + 1 == n);
        pending_words.push_back(tw);
      end
      foreach (adj[i, j]) adj[i][j] = '0;
      graphs_done++;
    endfunction

    // Compares one accepted result word with the oldest expectation.
    function void check_word(tb_pmst_types_pkg::tree_word_t got);
      tb_pmst_types_pkg::tree_word_t exp_w;
      if (pending_words.size() == 0) begin
        $error("unexpected result word child=%0d", got.child_vertex);
        err_cnt++;
        return;
      end
      exp_w = pending_words.pop_front();
      words_checked++;
      if (got.parent_vertex !== exp_w.parent_vertex) begin
        $error("parent_vertex exp %0d got %0d", exp_w.parent_vertex, got.parent_vertex);
        err_cnt++;
      end
      if (got.child_vertex !== exp_w.child_vertex) begin
        $error("child_vertex exp %0d got %0d", exp_w.child_vertex, got.child_vertex);
        err_cnt++;
      end
      if (got.tree_weight !== exp_w.tree_weight) begin
        $error("tree_weight exp %0d got %0d", exp_w.tree_weight, got.tree_weight);
        err_cnt++;
      end
      if (got.reached !== exp_w.reached) begin
        $error("reached exp %0d got %0d", exp_w.reached, got.reached);
        err_cnt++;
      end
      if (got.cost_sum !== exp_w.cost_sum) begin
        $error("cost_sum exp %0d got %0d", exp_w.cost_sum, got.cost_sum);
        err_cnt++;
      end
      if (got.last_result !== exp_w.last_result) begin
        $error("last_result exp %0d got %0d", exp_w.last_result, got.last_result);
        err_cnt++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CW-1:0] cfg_wdata_i = '0;
  bit no_idle = 0;
  int cycle_cnt = 0;
  int edges_sent = 0;

  pmst_edge_if edge_ch ();
  pmst_res_if  res_ch ();

  mst_scoreboard sb = new();

  prim_mst_dense_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .edge_i     (edge_ch.sink),
    .res_o      (res_ch.source)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    edge_ch.valid = 1'b0;
    edge_ch.from_vertex = '0;
    edge_ch.to_vertex = '0;
    edge_ch.weight = '0;
    edge_ch.last_edge = 1'b0;
    res_ch.ready = 1'b0;
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Samples result words at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      sb.check_word('{res_ch.parent_vertex, res_ch.child_vertex, res_ch.tree_weight,
                      res_ch.reached, res_ch.cost_sum, res_ch.last_result});
    end
  end

  // Result-side stalls come in random bursts.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 7);
        res_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_ch.ready = 1'b1;
    end
  end

  // Sends one edge word, with a random idle burst in front of it sometimes.
  task automatic send_edge(int u, int v, int w, bit last);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      edge_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    edge_ch.valid = 1'b1;
    edge_ch.from_vertex = u[VW-1:0];
    edge_ch.to_vertex = v[VW-1:0];
    edge_ch.weight = w[WW-1:0];
    edge_ch.last_edge = last;
    do @(posedge clk_i); while (!edge_ch.ready);
    sb.note_edge(u[VW-1:0], v[VW-1:0], w[WW-1:0], last);
    edges_sent++;
    @(negedge clk_i);
    edge_ch.valid = 1'b0;
  endtask

  // Writes the vertex count once all results are in and the block has settled.
  task automatic set_vertex_count(int c);
    while (sb.pending_words.size() != 0) @(negedge clk_i);
    repeat (3 * NumV + 10) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = c[CW-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_count(c[CW-1:0]);
  endtask

  // Mostly in-range edges forming a connected-ish graph, plus stray ones.
  task automatic random_graph(int n, int nedges);
    int u;
    int v;
    int w;
    for (int k = 0; k < nedges; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        u = k % n;
        v = (k + 1) % n;
      end else begin
        u = $urandom_range(0, (k % 8 == 7) ? 31 : n - 1);
        v = $urandom_range(0, n - 1);
      end
      case ($urandom_range(0, 7))
        0: w = 0;
        1: w = 16'hFFFF;
        2: w = $urandom_range(1, 3);
        default: w = $urandom_range(0, 65535);
      endcase
      send_edge(u, v, w, k == nedges - 1);
    end
  endtask

  initial begin
    int n;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: full size at reset count, extreme weights, self loop, overwritten edge.
    send_edge(0, 31, 16'hFFFF, 0);
    send_edge(31, 30, 1, 0);
    send_edge(5, 5, 7, 0);
    send_edge(0, 1, 16'hFFFF, 0);
    send_edge(1, 0, 2, 0);
    send_edge(2, 3, 9, 1);
    // Smallest graph: disconnected, connected, ignored endpoint, count 0/1 mapping to 2, 63 to 32.
    set_vertex_count(2);
    send_edge(0, 1, 0, 1);
    send_edge(1, 0, 16'hFFFF, 1);
    send_edge(0, 2, 5, 1);
    set_vertex_count(0);
    send_edge(1, 0, 3, 1);
    set_vertex_count(1);
    send_edge(0, 1, 4, 1);
    set_vertex_count(63);
    send_edge(31, 0, 8, 0);
    send_edge(1, 2, 8, 0);
    send_edge(0, 2, 8, 1);
    // Ties: equal weights pick the lowest index.
    set_vertex_count(4);
    send_edge(0, 1, 5, 0);
    send_edge(0, 2, 5, 0);
    send_edge(0, 3, 5, 0);
    send_edge(1, 3, 5, 0);
    send_edge(3, 7, 1, 1);

    // Random graphs, mostly small.
    while (edges_sent < 460) begin
      if (edges_sent > 400) no_idle = 1;
      n = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(2, 10);
      set_vertex_count(n);
      random_graph(n, $urandom_range(1, 3 * n));
    end

    while (sb.pending_words.size() != 0) @(negedge clk_i);
    repeat (3 * NumV + 10) @(negedge clk_i);
    $display("Covered %0d edge words, %0d graphs, %0d tree words checked.",
             edges_sent, sb.graphs_done, sb.words_checked);
    if (sb.err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pmst_pkg.sv
rtl/pmst_ifs.sv
rtl/pmst_cell.sv
rtl/prim_mst_dense_top.sv
rtl/pmst_checker.sv
sim/tb_prim_mst_dense_ifs.sv
sim/tb_prim_mst_dense_top.sv
